FILE: sv/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and codes of the memory test sequencer: command, status,
// function and phase codes, register indexes and the word structs.
// ----------------------------------------------------------------------------
package mts_pkg;

    // Input function codes
    localparam logic [1:0] FN_START = 2'd0;
    localparam logic [1:0] FN_WDONE = 2'd1;
    localparam logic [1:0] FN_RDATA = 2'd2;

    // Output command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_DONE  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Report status codes
    localparam logic [2:0] ST_RUN      = 3'd0;
    localparam logic [2:0] ST_PASS     = 3'd1;
    localparam logic [2:0] ST_MISMATCH = 3'd2;
    localparam logic [2:0] ST_WERR     = 3'd3;
    localparam logic [2:0] ST_RERR     = 3'd4;

    // Test modes
    localparam logic [1:0] MODE_SINGLE = 2'd0;
    localparam logic [1:0] MODE_MATS   = 2'd1;
    localparam logic [1:0] MODE_PAT    = 2'd2;

    // Sequencer phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_SINGLE = 3'd1;
    localparam logic [2:0] PH_M1     = 3'd2;
    localparam logic [2:0] PH_M2     = 3'd3;
    localparam logic [2:0] PH_M3     = 3'd4;
    localparam logic [2:0] PH_PAT    = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_TEST_MODE    = 2'd0;
    localparam logic [1:0] CFG_SINGLE_VALUE = 2'd1;
    localparam logic [1:0] CFG_CELL_COUNT   = 2'd2;

    // Field widths and data patterns
    localparam int CFG_COUNT_W = 17;
    localparam int CFG_DATA_W  = 17;
    localparam logic [7:0] PAT_ZERO = 8'h00;
    localparam logic [7:0] PAT_ONES = 8'hFF;
    localparam logic [7:0] PAT_ALT  = 8'h55;

    // Reset values of the configuration registers
    localparam logic [1:0]             RST_TEST_MODE  = MODE_MATS;
    localparam logic [7:0]             RST_SINGLE     = 8'h00;
    localparam logic [CFG_COUNT_W-1:0] RST_CELL_COUNT = 17'd256;

    // Input word
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] read_data;
        logic       bus_error;
    } t_item;

    // Result word
    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [2:0]  status;
        logic [7:0]  value_read;
        logic [7:0]  value_expected;
        logic [2:0]  highest_bad_bit;
    } t_result;

endpackage

FILE: sv/mts_step.sv
// ----------------------------------------------------------------------------
// mts_step
// One sequencer step: from the held input word and the current test state,
// form the next memory request or report and the next test state.
// ----------------------------------------------------------------------------
module mts_step
    import mts_pkg::*;
#(
    parameter int ADDR_WIDTH = 16
) (
    input  t_item                   i_item,
    input  logic [1:0]              i_test_mode,
    input  logic [7:0]              i_single_value,
    input  logic [CFG_COUNT_W-1:0]  i_cell_count,
    input  logic [2:0]              i_phase,
    input  logic                    i_awaiting,
    input  logic [ADDR_WIDTH-1:0]   i_ptr,
    input  logic [ADDR_WIDTH:0]     i_count,
    input  logic [7:0]              i_value,
    output logic [2:0]              o_phase,
    output logic                    o_awaiting,
    output logic [ADDR_WIDTH-1:0]   o_ptr,
    output logic [ADDR_WIDTH:0]     o_count,
    output logic [7:0]              o_value,
    output t_result                 o_result
);

    localparam int CNT_W  = ADDR_WIDTH + 1;
    localparam int EXT_W  = (CNT_W > CFG_COUNT_W) ? CNT_W : CFG_COUNT_W;
    localparam int WIDE_W = ADDR_WIDTH + 16;

    logic [EXT_W-1:0]      cnt_ext;
    logic [EXT_W-1:0]      cnt_limit;
    logic [EXT_W-1:0]      cnt_sat;
    logic [CNT_W-1:0]      ptr_inc;
    logic [CNT_W-1:0]      cnt_last;
    logic [WIDE_W-1:0]     ptr_wide;
    logic [15:0]           ptr_addr;
    logic [7:0]            expected;
    logic [7:0]            diff;
    logic [2:0]            bad_bit;

    // Clamp the cell count to between one cell and the whole address space
    always_comb begin
        cnt_ext   = EXT_W'(i_cell_count);
        cnt_limit = EXT_W'(1) << ADDR_WIDTH;
        cnt_sat   = cnt_ext;
        if (cnt_ext == '0) begin
            cnt_sat = EXT_W'(1);
        end else if (cnt_ext > cnt_limit) begin
            cnt_sat = cnt_limit;
        end
    end

    // Pointer arithmetic and the reported address
    assign ptr_inc  = {1'b0, i_ptr} + CNT_W'(1);
    assign cnt_last = i_count - CNT_W'(1);
    assign ptr_wide = WIDE_W'(i_ptr);
    assign ptr_addr = ptr_wide[15:0];

    // Expected byte for the read in the current phase
    always_comb begin
        case (i_phase)
            PH_SINGLE: expected = i_value;
            PH_M2:     expected = PAT_ZERO;
            PH_M3:     expected = PAT_ONES;
            default:   expected = PAT_ALT;
        endcase
    end

    // Find the highest differing bit
    assign diff = i_item.read_data ^ expected;
    always_comb begin
        bad_bit = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (diff[i]) begin
                bad_bit = 3'(i);
            end
        end
    end

    // Sequencer step
    always_comb begin
        o_phase    = i_phase;
        o_awaiting = i_awaiting;
        o_ptr      = i_ptr;
        o_count    = i_count;
        o_value    = i_value;
        o_result   = '0;
        o_result.command = CMD_NONE;
        o_result.status  = ST_RUN;

        if (i_item.func == FN_START) begin
            if (i_test_mode != MODE_SINGLE && i_test_mode != MODE_MATS &&
                i_test_mode != MODE_PAT) begin
                o_phase    = PH_IDLE;
                o_awaiting = 1'b0;
            end else begin
                o_count    = cnt_sat[CNT_W-1:0];
                o_value    = i_single_value;
                o_ptr      = '0;
                o_awaiting = 1'b0;
                o_result.command = CMD_WRITE;
                o_result.address = 16'd0;
                case (i_test_mode)
                    MODE_SINGLE: begin
                        o_phase = PH_SINGLE;
                        o_result.write_data = i_single_value;
                    end
                    MODE_MATS: begin
                        o_phase = PH_M1;
                        o_result.write_data = PAT_ZERO;
                    end
                    default: begin
                        o_phase = PH_PAT;
                        o_result.write_data = PAT_ALT;
                    end
                endcase
            end
        end else if (i_item.func == FN_WDONE && i_phase != PH_IDLE && !i_awaiting) begin
            if (i_item.bus_error) begin
                o_phase    = PH_IDLE;
                o_awaiting = 1'b0;
                o_result.command = CMD_DONE;
                o_result.status  = ST_WERR;
                o_result.address = ptr_addr;
            end else begin
                case (i_phase)
                    PH_SINGLE, PH_PAT: begin
                        o_awaiting = 1'b1;
                        o_result.command = CMD_READ;
                        o_result.address = ptr_addr;
                    end
                    PH_M1: begin
                        if (ptr_inc < i_count) begin
                            o_ptr = ptr_inc[ADDR_WIDTH-1:0];
                            o_result.command    = CMD_WRITE;
                            o_result.write_data = PAT_ZERO;
                        end else begin
                            o_phase    = PH_M2;
                            o_ptr      = '0;
                            o_awaiting = 1'b1;
                            o_result.command = CMD_READ;
                        end
                        o_result.address = 16'(WIDE_W'(o_ptr));
                    end
                    PH_M2: begin
                        o_awaiting = 1'b1;
                        o_result.command = CMD_READ;
                        if (ptr_inc < i_count) begin
                            o_ptr = ptr_inc[ADDR_WIDTH-1:0];
                        end else begin
                            o_phase = PH_M3;
                            o_ptr   = cnt_last[ADDR_WIDTH-1:0];
                        end
                        o_result.address = 16'(WIDE_W'(o_ptr));
                    end
                    default: begin
                        if (i_ptr == '0) begin
                            o_phase    = PH_IDLE;
                            o_awaiting = 1'b0;
                            o_result.command = CMD_DONE;
                            o_result.status  = ST_PASS;
                        end else begin
                            o_ptr      = i_ptr - ADDR_WIDTH'(1);
                            o_awaiting = 1'b1;
                            o_result.command = CMD_READ;
                            o_result.address = 16'(WIDE_W'(o_ptr));
                        end
                    end
                endcase
            end
        end else if (i_item.func == FN_RDATA && i_phase != PH_IDLE && i_awaiting) begin
            if (i_item.bus_error) begin
                o_phase    = PH_IDLE;
                o_awaiting = 1'b0;
                o_result.command = CMD_DONE;
                o_result.status  = ST_RERR;
                o_result.address = ptr_addr;
            end else if (diff != 8'h00) begin
                o_phase    = PH_IDLE;
                o_awaiting = 1'b0;
                o_result.command         = CMD_DONE;
                o_result.status          = ST_MISMATCH;
                o_result.address         = ptr_addr;
                o_result.value_read      = i_item.read_data;
                o_result.value_expected  = expected;
                o_result.highest_bad_bit = bad_bit;
            end else begin
                case (i_phase)
                    PH_SINGLE: begin
                        o_phase    = PH_IDLE;
                        o_awaiting = 1'b0;
                        o_result.command = CMD_DONE;
                        o_result.status  = ST_PASS;
                    end
                    PH_M2: begin
                        o_awaiting = 1'b0;
                        o_result.command    = CMD_WRITE;
                        o_result.address    = ptr_addr;
                        o_result.write_data = PAT_ONES;
                    end
                    PH_M3: begin
                        o_awaiting = 1'b0;
                        o_result.command    = CMD_WRITE;
                        o_result.address    = ptr_addr;
                        o_result.write_data = PAT_ZERO;
                    end
                    default: begin
                        o_awaiting = 1'b0;
                        if (ptr_inc < i_count) begin
                            o_ptr = ptr_inc[ADDR_WIDTH-1:0];
                            o_result.command    = CMD_WRITE;
                            o_result.address    = 16'(WIDE_W'(o_ptr));
                            o_result.write_data = PAT_ALT;
                        end else begin
                            o_phase = PH_IDLE;
                            o_result.command = CMD_DONE;
                            o_result.status  = ST_PASS;
                        end
                    end
                endcase
            end
        end
    end

endmodule

FILE: sv/memory_test_sequencer.sv
// Flow: an accepted word is held in the input register; the step loads its
//   result into the output register once that is free or draining.
// Throughput: one word per cycle while the output is taken; a full output
//   register that is not taken stalls the step and the input channel.
// Reset: synchronous, active low; the test returns to idle and the
//   configuration registers take mode MATS+, value 0x00 and 256 cells.
// ----------------------------------------------------------------------------
// memory_test_sequencer
// Byte-memory self-test sequencer: single cell, MATS+ march and 0x55
// pattern tests, driven by start, write acknowledge and read data words.
// ----------------------------------------------------------------------------
module memory_test_sequencer
    import mts_pkg::*;
#(
    parameter int ADDR_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // Input channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_func,
    input  logic [7:0]              i_read_data,
    input  logic                    i_bus_error,
    // Output channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [1:0]              o_command,
    output logic [15:0]             o_address,
    output logic [7:0]              o_write_data,
    output logic [2:0]              o_status,
    output logic [7:0]              o_value_read,
    output logic [7:0]              o_value_expected,
    output logic [2:0]              o_highest_bad_bit
);

    logic [1:0]             r_test_mode;
    logic [7:0]             r_single_value;
    logic [CFG_COUNT_W-1:0] r_cell_count;

    logic                   r_in_valid;
    t_item                  r_in_item;
    logic                   r_out_valid;
    t_result                r_out;

    logic [2:0]             r_phase;
    logic                   r_awaiting;
    logic [ADDR_WIDTH-1:0]  r_ptr;
    logic [ADDR_WIDTH:0]    r_count;
    logic [7:0]             r_value;

    logic [2:0]             n_phase;
    logic                   n_awaiting;
    logic [ADDR_WIDTH-1:0]  n_ptr;
    logic [ADDR_WIDTH:0]    n_count;
    logic [7:0]             n_value;
    t_result                n_out;

    logic                   step_go;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_test_mode    <= RST_TEST_MODE;
            r_single_value <= RST_SINGLE;
            r_cell_count   <= RST_CELL_COUNT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TEST_MODE:    r_test_mode    <= i_cfg_data[1:0];
                CFG_SINGLE_VALUE: r_single_value <= i_cfg_data[7:0];
                CFG_CELL_COUNT:   r_cell_count   <= i_cfg_data[CFG_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Step when a word is held and the output register is free or draining
    assign step_go = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || step_go;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_item <= '{func: i_func, read_data: i_read_data, bus_error: i_bus_error};
        end
    end

    mts_step #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_step (
        .i_item         (r_in_item),
        .i_test_mode    (r_test_mode),
        .i_single_value (r_single_value),
        .i_cell_count   (r_cell_count),
        .i_phase        (r_phase),
        .i_awaiting     (r_awaiting),
        .i_ptr          (r_ptr),
        .i_count        (r_count),
        .i_value        (r_value),
        .o_phase        (n_phase),
        .o_awaiting     (n_awaiting),
        .o_ptr          (n_ptr),
        .o_count        (n_count),
        .o_value        (n_value),
        .o_result       (n_out)
    );

    // Test state: advance on each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_awaiting <= 1'b0;
            r_ptr      <= '0;
            r_count    <= (ADDR_WIDTH + 1)'(1);
            r_value    <= 8'h00;
        end else if (step_go) begin
            r_phase    <= n_phase;
            r_awaiting <= n_awaiting;
            r_ptr      <= n_ptr;
            r_count    <= n_count;
            r_value    <= n_value;
        end
    end

    // Output register: load on a step, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_go) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_out <= n_out;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_command         = r_out.command;
    assign o_address         = r_out.address;
    assign o_write_data      = r_out.write_data;
    assign o_status          = r_out.status;
    assign o_value_read      = r_out.value_read;
    assign o_value_expected  = r_out.value_expected;
    assign o_highest_bad_bit = r_out.highest_bad_bit;

    // Requests always carry running status
    a_req_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.command == CMD_WRITE || r_out.command == CMD_READ))
            |-> (r_out.status == ST_RUN))
        else $error("request word without running status");

    // Idle test never waits for read data
    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> !r_awaiting)
        else $error("idle sequencer awaiting read data");

    // Pointer stays inside the swept range while a test runs
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> ({1'b0, r_ptr} < r_count))
        else $error("cell pointer beyond cell count");

    // No result word straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule
